### src/tcw_pkg.sv
// Shared types, constants and geometry of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int CELL_AW = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  localparam int POS_OUT_W = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int CELL_W    = 16;

  localparam logic [7:0] BLANK_ATTR     = 8'h0F;
  localparam logic [7:0] SPACE_CHAR     = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [7:0] BACKSPACE_CHAR = 8'h08;

  typedef enum logic [1:0] {
    REQ_PUT     = 2'd0,
    REQ_CLEAR   = 2'd1,
    REQ_BS_WRAP = 2'd2,
    REQ_READ    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OP_PUTC,
    OP_NEWLINE,
    OP_BS_NOWRAP,
    OP_CLEAR,
    OP_BS_WRAP,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [7:0]  color;
    logic [10:0] cell_index;
  } in_req_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0] cursor_pos;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_line;
    logic [CELL_W-1:0]    cell_data;
  } out_res_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         char_code;
    logic [7:0]         color;
    logic               read_ok;
    logic [CELL_AW-1:0] addr;
  } cmd_t;

endpackage

### src/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tcw_front.sv
// Request decode and two-entry command queue feeding the execution side.
`timescale 1ns / 1ps
module tcw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcw_pkg::in_req_t in_data,
  input  logic             init_done,
  output logic             cmd_valid,
  input  logic             cmd_pop,
  output tcw_pkg::cmd_t    cmd
);
  import tcw_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cmd_in;
  logic       push;

  // Split put-character requests by their control bytes so the back end
  // only sees one operation per command.
  always_comb begin
    cmd_in.char_code = in_data.char_code;
    cmd_in.color     = in_data.color;
    cmd_in.read_ok   = (32'(in_data.cell_index) < CELLS);
    cmd_in.addr      = CELL_AW'(in_data.cell_index);
    case (req_t'(in_data.req_type))
      REQ_PUT: begin
        if (in_data.char_code == NEWLINE_CHAR) begin
          cmd_in.op = OP_NEWLINE;
        end else if (in_data.char_code == BACKSPACE_CHAR) begin
          cmd_in.op = OP_BS_NOWRAP;
        end else begin
          cmd_in.op = OP_PUTC;
        end
      end
      REQ_CLEAR:   cmd_in.op = OP_CLEAR;
      REQ_BS_WRAP: cmd_in.op = OP_BS_WRAP;
      REQ_READ:    cmd_in.op = OP_READ;
      default:     cmd_in.op = OP_READ;
    endcase
  end

  assign in_ready  = init_done && (count_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (count_r != 2'd0))
    else $error("command popped from an empty queue");

  a_no_push_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !push)
    else $error("request accepted during the clearing pass");

endmodule

### src/tcw_back.sv
// Execution sequencer: cursor, screen store passes and the result register.
`timescale 1ns / 1ps
module tcw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  tcw_pkg::cmd_t     cmd,
  output logic              init_done,
  output logic              out_valid,
  input  logic              out_ready,
  output tcw_pkg::out_res_t out_data
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_READ
  } state_t;

  localparam logic [COL_W-1:0]   LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [CELL_AW-1:0] SCROLL_POS = CELL_AW'(CELLS - COLUMNS);
  localparam logic [CELL_AW-1:0] COPY_LAST  = CELL_AW'(CELLS - COLUMNS - 1);
  localparam logic [CELL_AW-1:0] LAST_CELL  = CELL_AW'(CELLS - 1);
  localparam logic [CELL_AW-1:0] ROW_STEP   = CELL_AW'(COLUMNS);

  state_t             state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CELL_AW-1:0] pos_r, pos_nxt;
  logic [CELL_AW-1:0] cnt_r, cnt_nxt;
  logic [CELL_W-1:0]  fill_data_r, fill_data_nxt;
  logic               fill_resp_r, fill_resp_nxt;
  logic               init_done_r, init_done_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [CELL_AW-1:0] wr_addr_r, wr_addr_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_res_t           out_data_r, out_data_nxt;

  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_AW-1:0] ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  logic               out_free;
  logic               out_load;
  logic [CELL_W-1:0]  out_cell;
  logic [CELL_W-1:0]  blank_color;
  logic [CELL_W-1:0]  blank_fixed;
  logic [CELL_AW-1:0] pos_dec;
  logic [CELL_AW-1:0] pos_newline;

  assign out_free    = !out_valid_r || out_ready;
  assign blank_color = {cmd.color, SPACE_CHAR};
  assign blank_fixed = {BLANK_ATTR, SPACE_CHAR};
  assign pos_dec     = pos_r - CELL_AW'(1);
  assign pos_newline = pos_r - CELL_AW'(col_r) + ROW_STEP;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    fill_data_nxt = fill_data_r;
    fill_resp_nxt = fill_resp_r;
    init_done_nxt = init_done_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    rd_ok_nxt     = rd_ok_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = blank_color;
    ram_raddr     = cmd.addr;
    cmd_pop       = 1'b0;
    out_load      = 1'b0;
    out_cell      = '0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_PUTC: begin
              ram_we    = 1'b1;
              ram_waddr = pos_r;
              ram_wdata = {cmd.color, cmd.char_code};
              pos_nxt   = pos_r + CELL_AW'(1);
              if (col_r == LAST_COL) begin
                col_nxt = '0;
                if (row_r == LAST_ROW) begin
                  pos_nxt       = SCROLL_POS;
                  cnt_nxt       = '0;
                  fill_data_nxt = blank_color;
                  state_nxt     = ST_COPY;
                end else begin
                  row_nxt  = row_r + ROW_W'(1);
                  out_load = 1'b1;
                end
              end else begin
                col_nxt  = col_r + COL_W'(1);
                out_load = 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_nxt = '0;
              if (row_r == LAST_ROW) begin
                pos_nxt       = SCROLL_POS;
                cnt_nxt       = '0;
                fill_data_nxt = blank_color;
                state_nxt     = ST_COPY;
              end else begin
                row_nxt  = row_r + ROW_W'(1);
                pos_nxt  = pos_newline;
                out_load = 1'b1;
              end
            end
            OP_BS_NOWRAP: begin
              if (col_r != '0) begin
                col_nxt   = col_r - COL_W'(1);
                pos_nxt   = pos_dec;
                ram_we    = 1'b1;
                ram_waddr = pos_dec;
                ram_wdata = blank_color;
              end
              out_load = 1'b1;
            end
            OP_BS_WRAP: begin
              if (col_r != '0) begin
                col_nxt   = col_r - COL_W'(1);
                pos_nxt   = pos_dec;
                ram_we    = 1'b1;
                ram_waddr = pos_dec;
                ram_wdata = blank_fixed;
              end else if (row_r != '0) begin
                row_nxt   = row_r - ROW_W'(1);
                col_nxt   = LAST_COL;
                pos_nxt   = pos_dec;
                ram_we    = 1'b1;
                ram_waddr = pos_dec;
                ram_wdata = blank_fixed;
              end
              out_load = 1'b1;
            end
            OP_CLEAR: begin
              col_nxt       = '0;
              row_nxt       = '0;
              pos_nxt       = '0;
              cnt_nxt       = '0;
              fill_data_nxt = blank_color;
              fill_resp_nxt = 1'b1;
              state_nxt     = ST_FILL;
            end
            OP_READ: begin
              ram_raddr = cmd.addr;
              rd_ok_nxt = cmd.read_ok;
              state_nxt = ST_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_COPY: begin
        // Read one row ahead, write the cell back in the following cycle.
        ram_raddr   = cnt_r + ROW_STEP;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = cnt_r;
        ram_we      = wr_pend_r;
        ram_waddr   = wr_addr_r;
        ram_wdata   = ram_rdata;
        if (cnt_r == COPY_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CELL_AW'(1);
        end
      end
      ST_DRAIN: begin
        ram_we        = 1'b1;
        ram_waddr     = wr_addr_r;
        ram_wdata     = ram_rdata;
        cnt_nxt       = SCROLL_POS;
        fill_resp_nxt = 1'b1;
        state_nxt     = ST_FILL;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = fill_data_r;
        if (cnt_r == LAST_CELL) begin
          state_nxt     = ST_IDLE;
          init_done_nxt = 1'b1;
          out_load      = fill_resp_r;
        end else begin
          cnt_nxt = cnt_r + CELL_AW'(1);
        end
      end
      ST_READ: begin
        out_load  = 1'b1;
        out_cell  = rd_ok_r ? ram_rdata : '0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.cursor_pos  = POS_OUT_W'(pos_nxt);
      out_data_nxt.cursor_col  = COL_OUT_W'(col_nxt);
      out_data_nxt.cursor_line = ROW_OUT_W'(row_nxt);
      out_data_nxt.cell_data   = out_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      col_r       <= '0;
      row_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      fill_data_r <= '0;
      fill_resp_r <= 1'b0;
      init_done_r <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      fill_data_r <= fill_data_nxt;
      fill_resp_r <= fill_resp_nxt;
      init_done_r <= init_done_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wr_addr_r  <= wr_addr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign init_done = init_done_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over one still waiting");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < COLUMNS) && (32'(row_r) < ROWS))
    else $error("cursor outside the screen");

  a_pos_tracks_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |->
      (32'(pos_r) == 32'(row_r) * COLUMNS + 32'(col_r)))
    else $error("linear position out of step with the cursor");

endmodule

### src/text_console_writer_unit.sv
// Top level of the text console writer: request front end, queue and executor.
`timescale 1ns / 1ps
// Put character, newline, backspace: the result is registered after acceptance,
// through the queue entry and then the executor; read cell adds the store read.
// Throughput: one such transaction per cycle, set by the executor's single pass,
// while results are taken and no scroll runs. Clear screen and scroll pass over
// the store cell by cell, limited by the one write port of the screen store; a
// scroll copies rows up and blanks the last row. After reset a clearing pass
// zeroes the store while in_ready stays low; the cursor resets to home.
module text_console_writer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tcw_pkg::out_res_t out_data
);
  import tcw_pkg::*;

  // Commands leave the front queue one per transaction; the executor pops
  // one only when the result register can take its answer.
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  logic init_done;

  // The front end decodes each request and buffers up to two commands, so
  // the input side keeps moving while a result waits to be taken.
  tcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .init_done(init_done),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  // The executor owns the cursor and the screen store, and runs the long
  // passes (clear, scroll, reset clear) over the store one cell a cycle.
  tcw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .init_done(init_done),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
